/* hw/rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 stream transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [5:0]  CONT_MASK      = 6'h3f;
    localparam logic [31:0] BMP_MAX        = 32'h0000_ffff;
    localparam logic [31:0] SUPP_BASE      = 32'h0001_0000;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hd800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hdc00;
    localparam logic [9:0]  SURR_MASK      = 10'h3ff;

    typedef struct packed {
        logic [15:0] word_out;
        logic        run_last;
        logic        string_done;
        logic        truncated;
    } result_t;

    typedef struct packed {
        logic [2:0]  bytes_pending;
        logic [31:0] code_accum;
    } state_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } decode_t;

endpackage

/* hw/rtl/u8u16_byte_if.sv */
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Byte request channel: one UTF-8 byte and the end-of-string flag.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       string_end;

    modport source (output valid, output byte_in, output string_end, input ready);
    modport sink   (input valid, input byte_in, input string_end, output ready);

endinterface

/* hw/rtl/u8u16_word_if.sv */
// ----------------------------------------------------------------------------
// u8u16_word_if
// Word request channel: one UTF-16 code unit and its status flags.
// ----------------------------------------------------------------------------
interface u8u16_word_if;

    logic        valid;
    logic        ready;
    logic [15:0] word_out;
    logic        run_last;
    logic        string_done;
    logic        truncated;

    modport source (
        output valid, output word_out, output run_last,
        output string_done, output truncated, input ready
    );
    modport sink (
        input valid, input word_out, input run_last,
        input string_done, input truncated, output ready
    );

endinterface

/* hw/rtl/u8u16_decoder.sv */
// ----------------------------------------------------------------------------
// u8u16_decoder
// Single-pass decode of one byte: next sequence state and up to two words.
// ----------------------------------------------------------------------------
module u8u16_decoder (
    input  logic [7:0]        byte_in,
    input  logic              string_end,
    input  u8u16_pkg::state_t state_cur,
    output u8u16_pkg::state_t state_nxt,
    output u8u16_pkg::decode_t dec
);

    logic [3:0]        lead_cnt;
    logic              run;
    logic [7:0]        lead_mask;
    u8u16_pkg::state_t upd;
    logic [31:0]       supp_val;

    always_comb
    begin
        lead_cnt = 4'd0;
        run      = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            if (run && byte_in[i])
            begin
                lead_cnt = lead_cnt + 4'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    assign lead_mask = 8'hff >> (lead_cnt + 4'd1);

    always_comb
    begin
        if (state_cur.bytes_pending != 3'd0)
        begin
            upd.code_accum    = {state_cur.code_accum[25:0], byte_in[5:0] & u8u16_pkg::CONT_MASK};
            upd.bytes_pending = state_cur.bytes_pending - 3'd1;
        end
        else
        begin
            upd.code_accum    = {24'd0, byte_in & lead_mask};
            upd.bytes_pending = (lead_cnt <= 4'd1) ? 3'd0 : 3'(lead_cnt - 4'd1);
        end
    end

    assign supp_val = upd.code_accum - u8u16_pkg::SUPP_BASE;

    always_comb
    begin
        dec       = '0;
        state_nxt = upd;
        if (upd.bytes_pending != 3'd0)
        begin
            if (string_end)
            begin
                dec.count             = 2'd1;
                dec.first.word_out    = 16'd0;
                dec.first.run_last    = 1'b1;
                dec.first.string_done = 1'b1;
                dec.first.truncated   = 1'b1;
                state_nxt             = '0;
            end
        end
        else
        begin
            if (upd.code_accum <= u8u16_pkg::BMP_MAX)
            begin
                dec.count             = 2'd1;
                dec.first.word_out    = upd.code_accum[15:0];
                dec.first.run_last    = 1'b1;
                dec.first.string_done = string_end;
            end
            else
            begin
                dec.count              = 2'd2;
                dec.first.word_out     = u8u16_pkg::HIGH_SURR_BASE
                                       | {6'd0, supp_val[19:10] & u8u16_pkg::SURR_MASK};
                dec.second.word_out    = u8u16_pkg::LOW_SURR_BASE
                                       | {6'd0, supp_val[9:0] & u8u16_pkg::SURR_MASK};
                dec.second.run_last    = 1'b1;
                dec.second.string_done = string_end;
            end
            if (string_end)
            begin
                state_nxt = '0;
            end
        end
    end

endmodule

/* hw/rtl/utf8_to_utf16_stream_unit.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_unit
// Streaming UTF-8 to UTF-16 transcoder with explicit end-of-string flag.
// ----------------------------------------------------------------------------
// One UTF-8 byte is accepted per cycle when there is room, and its words are
// registered. A byte that completes a character up to 0xFFFF, or ends a
// string inside a sequence, gives one word; a byte inside a sequence gives
// none; a byte that completes a larger value gives a high and then a low
// surrogate. The two-slot result buffer sets the rate: it drains one word per
// cycle while the receiver is ready and takes a new byte when it is empty or
// its last word leaves in that cycle, so plain text runs at one byte per cycle.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_unit (
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    byte_chan,
    u8u16_word_if.source  word_chan
);

    u8u16_pkg::state_t  state_reg;
    u8u16_pkg::state_t  state_next;
    u8u16_pkg::decode_t dec;
    u8u16_pkg::result_t slot0_reg;
    u8u16_pkg::result_t slot1_reg;
    logic [1:0]         count_reg;
    logic               accept;
    logic               pop;

    u8u16_decoder u_decoder (
        .byte_in    (byte_chan.byte_in),
        .string_end (byte_chan.string_end),
        .state_cur  (state_reg),
        .state_nxt  (state_next),
        .dec        (dec)
    );

    assign pop             = word_chan.valid && word_chan.ready;
    assign byte_chan.ready = (count_reg == 2'd0) || (count_reg == 2'd1 && word_chan.ready);
    assign accept          = byte_chan.valid && byte_chan.ready;

    assign word_chan.valid       = (count_reg != 2'd0);
    assign word_chan.word_out    = slot0_reg.word_out;
    assign word_chan.run_last    = slot0_reg.run_last;
    assign word_chan.string_done = slot0_reg.string_done;
    assign word_chan.truncated   = slot0_reg.truncated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            count_reg <= dec.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot0_reg <= dec.first;
            slot1_reg <= dec.second;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !slot0_reg.run_last)
        else $error("high surrogate flagged as last word");

    a_pair_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && pop) |=> (count_reg == 2'd1 && slot0_reg.run_last))
        else $error("low surrogate not presented after high surrogate");

    a_trunc_word: assert property (@(posedge clk) disable iff (!rst_n)
        (word_chan.valid && word_chan.truncated) |->
            (word_chan.word_out == 16'd0 && word_chan.run_last && word_chan.string_done))
        else $error("malformed truncation result");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_chan.string_end) |=>
            (state_reg.bytes_pending == 3'd0 && state_reg.code_accum == 32'd0))
        else $error("sequence state not cleared at string end");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the UTF-8 to UTF-16 stream transcoder. Directed strings cover
// plain bytes, stray continuations, multibyte and surrogate characters, long
// prefixes and strings cut mid-sequence. Random text follows: mostly
// well-formed sequences with random content, mixed with noise bytes. Each word
// is checked by a local decoder; both sides stall at random bar the last run.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;

    u8u16_byte_if byte_chan ();
    u8u16_word_if word_chan ();

    utf8_to_utf16_stream_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .word_chan (word_chan)
    );

    u8u16_pkg::result_t utf16_expected[$];
    logic [2:0]         seq_remaining;
    logic [31:0]        code_value;

    int sender_idle_pct;
    int receiver_idle_pct;
    int bytes_sent;
    int error_count;
    int stall_cycles = 0;

    always #5 clk = ~clk;

    function automatic void predict_utf16_words(input logic [7:0] b, input logic last_byte);
        int          ones;
        logic [7:0]  keep;
        logic [31:0] offset;
        ones = 0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i] && ones == 7 - i)
                ones++;
        end
        if (seq_remaining != 3'd0)
        begin
            code_value    = {code_value[25:0], b[5:0] & u8u16_pkg::CONT_MASK};
            seq_remaining = seq_remaining - 3'd1;
        end
        else
        begin
            keep          = (ones >= 7) ? 8'h00 : (8'h01 << (7 - ones)) - 8'h01;
            code_value    = {24'h0, b & keep};
            seq_remaining = (ones <= 1) ? 3'd0 : 3'(ones - 1);
        end
        if (seq_remaining != 3'd0)
        begin
            if (last_byte)
            begin
                utf16_expected.push_back({16'h0000, 1'b1, 1'b1, 1'b1});
                seq_remaining = 3'd0;
                code_value    = 32'h0;
            end
            return;
        end
        if (code_value <= u8u16_pkg::BMP_MAX)
            utf16_expected.push_back({code_value[15:0], 1'b1, last_byte, 1'b0});
        else
        begin
            offset = code_value - u8u16_pkg::SUPP_BASE;
            utf16_expected.push_back(
                {u8u16_pkg::HIGH_SURR_BASE | {6'h0, offset[19:10] & u8u16_pkg::SURR_MASK},
                 1'b0, 1'b0, 1'b0});
            utf16_expected.push_back(
                {u8u16_pkg::LOW_SURR_BASE | {6'h0, offset[9:0] & u8u16_pkg::SURR_MASK},
                 1'b1, last_byte, 1'b0});
        end
        if (last_byte)
        begin
            seq_remaining = 3'd0;
            code_value    = 32'h0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 64)
            gap++;
        if (gap > 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_chan.valid      <= 1'b1;
        byte_chan.byte_in    <= b;
        byte_chan.string_end <= last_byte;
        @(negedge clk);
        while (!byte_chan.ready)
            @(negedge clk);
        @(posedge clk);
        predict_utf16_words(b, last_byte);
        bytes_sent++;
    endtask

    task automatic wait_words_drained();
        byte_chan.valid <= 1'b0;
        while (utf16_expected.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);
    endtask

    task automatic test_stray_continuation();
        send_byte(8'h80, 1'b0);
        send_byte(8'hbf, 1'b1);
    endtask

    task automatic test_multibyte();
        send_byte(8'hc3, 1'b0);
        send_byte(8'ha9, 1'b0);
        send_byte(8'hf0, 1'b0);
        send_byte(8'h9f, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_long_prefix();
        send_byte(8'hfe, 1'b0);
        for (int i = 0; i < 6; i++)
            send_byte(8'hff, i == 5);
    endtask

    task automatic test_truncated();
        send_byte(8'he2, 1'b1);
        send_byte(8'hf0, 1'b0);
        send_byte(8'h9f, 1'b1);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_random_text(input int count);
        int         stop_at;
        int         pick;
        int         len;
        int         cut;
        logic [7:0] lead;
        logic [7:0] b;
        logic       last_byte;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    len = 1;
                else if (pick < 55)
                    len = 2;
                else if (pick < 70)
                    len = 3;
                else if (pick < 85)
                    len = 4;
                else
                    len = $urandom_range(8, 5);
                if (len == 1)
                    lead = ($urandom_range(4) == 0) ? 8'h80 | 8'($urandom_range(63))
                                                    : 8'($urandom_range(127));
                else if (len == 8)
                    lead = 8'hff;
                else
                    lead = (8'hff << (8 - len)) |
                           (8'($urandom_range(255)) & ((8'h01 << (7 - len)) - 8'h01));
                cut = ($urandom_range(19) == 0) ? $urandom_range(len, 1) : len;
                for (int i = 0; i < cut; i++)
                begin
                    if (i == 0)
                        b = lead;
                    else if ($urandom_range(9) == 0)
                        b = 8'($urandom_range(255));
                    else
                        b = 8'h80 | 8'($urandom_range(63));
                    last_byte = (i == cut - 1) && (cut < len || $urandom_range(5) == 0);
                    send_byte(b, last_byte);
                end
            end
            else
                send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        end
    endtask

    always @(posedge clk)
    begin
        word_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        u8u16_pkg::result_t want;
        u8u16_pkg::result_t got;
        if (rst_n && word_chan.valid && word_chan.ready)
        begin
            got = {word_chan.word_out, word_chan.run_last,
                   word_chan.string_done, word_chan.truncated};
            if (utf16_expected.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected word %h last %b done %b trunc %b",
                             got.word_out, got.run_last, got.string_done, got.truncated);
                error_count++;
            end
            else
            begin
                want = utf16_expected.pop_front();
                if (got.word_out !== want.word_out || got.run_last !== want.run_last ||
                    got.string_done !== want.string_done ||
                    got.truncated !== want.truncated)
                begin
                    if (error_count < 10)
                        $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                                 want.word_out, want.run_last, want.string_done,
                                 want.truncated, got.word_out, got.run_last,
                                 got.string_done, got.truncated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_chan.valid && byte_chan.ready) || (word_chan.valid && word_chan.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        byte_chan.valid      = 1'b0;
        byte_chan.byte_in    = 8'h00;
        byte_chan.string_end = 1'b0;
        seq_remaining        = 3'd0;
        code_value           = 32'h0;
        bytes_sent           = 0;
        error_count          = 0;
        sender_idle_pct      = 26;
        receiver_idle_pct    = 69;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_stray_continuation();
        test_multibyte();
        test_long_prefix();
        test_truncated();
        wait_words_drained();

        test_random_text(170);
        wait_words_drained();
        sender_idle_pct   = 69;
        receiver_idle_pct = 26;
        test_random_text(170);
        wait_words_drained();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_text(170);

        byte_chan.valid <= 1'b0;
        while (utf16_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0 && utf16_expected.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_byte_if.sv
hw/rtl/u8u16_word_if.sv
hw/rtl/u8u16_decoder.sv
hw/rtl/utf8_to_utf16_stream_unit.sv
dv/tb_top.sv
